>>> src/rffe_bus_master_core_defines.svh
// Assertion macros shared by the bus master RTL.
// No dependencies; expects clk and arst_n in the including module.
`ifndef RFFE_BUS_MASTER_CORE_DEFINES_SVH
`define RFFE_BUS_MASTER_CORE_DEFINES_SVH

// same-cycle implication
`define RBM_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("rbm check failed");

// next-cycle implication
`define RBM_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("rbm check failed");

`endif

>>> src/rbm_pkg.sv
// Shared constants, codes and types of the RFFE bus master.
// No dependencies.
package rbm_pkg;

	localparam int MAX_BYTES_DEF = 4;
	localparam int CMD_BITS      = 13;
	localparam int WORD_BITS     = 9;
	localparam int RX_W          = 36;
	localparam int IQ_DEPTH      = 4;
	localparam int OQ_DEPTH      = 2;

	localparam logic [7:0] EXT_LIMIT_RST = 8'hBE;

	localparam logic [1:0] KIND_REG_WR = 2'd0;
	localparam logic [1:0] KIND_REG_RD = 2'd1;
	localparam logic [1:0] KIND_EXT_WR = 2'd2;
	localparam logic [1:0] KIND_EXT_RD = 2'd3;

	localparam logic [2:0] OP_REG_WR = 3'b010;
	localparam logic [2:0] OP_REG_RD = 3'b011;
	localparam logic [3:0] OP_EXT_WR = 4'b0000;
	localparam logic [3:0] OP_EXT_RD = 4'b0010;

	typedef struct packed {
		logic start;
		logic addr_err;
		logic is_read;
		logic sdin;
	} ctl_t;

	typedef struct packed {
		logic            sdata_out;
		logic            sdata_oe;
		logic            sclk_pulse;
		logic            busy_res;
		logic            done_res;
		logic            read_valid;
		logic [RX_W-1:0] read_bits;
		logic            addr_error;
	} res_t;

endpackage

>>> src/rbm_fifo.sv
// Small register FIFO used between front, back and the result port.
// No dependencies.
module rbm_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	input  logic         pop,
	output logic [W-1:0] dout,
	output logic         full,
	output logic         empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_push, do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

>>> src/rbm_front.sv
// Front end: classifies a bit-period item and builds the transmit frame.
// Depends on rbm_pkg.
module rbm_front #(
	parameter int MAX_BYTES = rbm_pkg::MAX_BYTES_DEF
) (
	input  logic                                          action,
	input  logic [1:0]                                    kind,
	input  logic [3:0]                                    slave_addr,
	input  logic [7:0]                                    target_reg,
	input  logic [2:0]                                    byte_count,
	input  logic [31:0]                                   write_data,
	input  logic                                          sdata_in,
	input  logic [7:0]                                    ext_limit,
	output rbm_pkg::ctl_t                                 ctl,
	output logic [rbm_pkg::CMD_BITS+rbm_pkg::WORD_BITS*(MAX_BYTES+1)-1:0] frame,
	output logic [$clog2(rbm_pkg::CMD_BITS+rbm_pkg::WORD_BITS*(MAX_BYTES+1)+1)-1:0] tx_len,
	output logic [$clog2(rbm_pkg::CMD_BITS+rbm_pkg::WORD_BITS*(MAX_BYTES+1)+1)-1:0] rx_len
);
	import rbm_pkg::*;

	localparam int TX_W = CMD_BITS + WORD_BITS * (MAX_BYTES + 1);
	localparam int CNT_W = $clog2(TX_W + 1);
	localparam int NB_W = ($clog2(MAX_BYTES + 1) > 4) ? $clog2(MAX_BYTES + 1) : 4;

	logic [7:0]           wb [MAX_BYTES];
	logic [WORD_BITS-1:0] wd [MAX_BYTES+1];
	logic [NB_W-1:0]      nb, nbm1;
	logic [CNT_W-1:0]     nb9;
	logic [11:0]          cmd;
	logic                 is_rd;

	genvar k;
	generate
		for (k = 0; k < MAX_BYTES; k++) begin : g_byte
			if (k < 4) begin : g_data
				assign wb[k] = write_data[8*k +: 8];
			end else begin : g_zero
				assign wb[k] = 8'h00;
			end
		end
	endgenerate

	always_comb begin
		nb = NB_W'(byte_count);
		if (nb == '0) begin
			nb = NB_W'(1);
		end
		if (nb > NB_W'(MAX_BYTES)) begin
			nb = NB_W'(MAX_BYTES);
		end
		nbm1 = nb - 1'b1;
		nb9  = (CNT_W'(nb) << 3) + CNT_W'(nb);
	end

	always_comb begin
		for (int w = 0; w <= MAX_BYTES; w++) begin
			wd[w] = '0;
		end
		cmd    = '0;
		is_rd  = 1'b0;
		tx_len = CNT_W'(CMD_BITS);
		rx_len = '0;
		case (kind)
			KIND_REG_WR: begin
				cmd    = {slave_addr, OP_REG_WR, target_reg[4:0]};
				wd[0]  = {write_data[7:0], ~^write_data[7:0]};
				tx_len = CNT_W'(CMD_BITS + WORD_BITS);
			end
			KIND_REG_RD: begin
				cmd    = {slave_addr, OP_REG_RD, target_reg[4:0]};
				is_rd  = 1'b1;
				rx_len = CNT_W'(WORD_BITS);
			end
			KIND_EXT_WR: begin
				cmd   = {slave_addr, OP_EXT_WR, nbm1[3:0]};
				wd[0] = {target_reg, ~^target_reg};
				for (int b = 0; b < MAX_BYTES; b++) begin
					if (NB_W'(b) < nb) begin
						wd[b+1] = {wb[b], ~^wb[b]};
					end
				end
				tx_len = CNT_W'(CMD_BITS + WORD_BITS) + nb9;
			end
			KIND_EXT_RD: begin
				cmd    = {slave_addr, OP_EXT_RD, nbm1[3:0]};
				wd[0]  = {target_reg, ~^target_reg};
				is_rd  = 1'b1;
				tx_len = CNT_W'(CMD_BITS + WORD_BITS);
				rx_len = nb9;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_comb begin
		frame = '0;
		frame[TX_W-1 -: CMD_BITS] = {cmd, ~^cmd};
		for (int w = 0; w <= MAX_BYTES; w++) begin
			frame[TX_W-1-CMD_BITS-WORD_BITS*w -: WORD_BITS] = wd[w];
		end
	end

	assign ctl.start    = action;
	assign ctl.addr_err = kind[1] && (target_reg > ext_limit);
	assign ctl.is_read  = is_rd;
	assign ctl.sdin     = sdata_in;

endmodule

>>> src/rbm_back.sv
// Back end: bus sequencer, one queued bit period per transfer into the result queue.
// Depends on rbm_pkg and rffe_bus_master_core_defines.svh.
`include "rffe_bus_master_core_defines.svh"
module rbm_back #(
	parameter int MAX_BYTES = rbm_pkg::MAX_BYTES_DEF
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          item_valid,
	input  logic                                          out_space,
	input  rbm_pkg::ctl_t                                 ctl,
	input  logic [rbm_pkg::CMD_BITS+rbm_pkg::WORD_BITS*(MAX_BYTES+1)-1:0] frame,
	input  logic [$clog2(rbm_pkg::CMD_BITS+rbm_pkg::WORD_BITS*(MAX_BYTES+1)+1)-1:0] tx_len,
	input  logic [$clog2(rbm_pkg::CMD_BITS+rbm_pkg::WORD_BITS*(MAX_BYTES+1)+1)-1:0] rx_len,
	output logic                                          take,
	output rbm_pkg::res_t                                 res
);
	import rbm_pkg::*;

	localparam int TX_W = CMD_BITS + WORD_BITS * (MAX_BYTES + 1);
	localparam int CNT_W = $clog2(TX_W + 1);

	typedef enum logic [2:0] {
		PH_IDLE, PH_SSC2, PH_TX, PH_PARK, PH_RX, PH_PARK2
	} phase_t;

	phase_t          phase_q;
	logic [CNT_W-1:0] cnt_q, tx_len_q, rx_len_q;
	logic [TX_W-1:0]  tx_q;
	logic [RX_W-1:0]  rx_q;
	logic             is_rd_q;
	logic [CNT_W:0]   cnt_inc;

	assign take    = item_valid && out_space;
	assign cnt_inc = {1'b0, cnt_q} + 1'b1;

	always_comb begin
		res = '0;
		case (phase_q)
			PH_IDLE: begin
				if (ctl.start) begin
					if (ctl.addr_err) begin
						res.done_res   = 1'b1;
						res.addr_error = 1'b1;
					end else begin
						res.sdata_out = 1'b1;
						res.sdata_oe  = 1'b1;
						res.busy_res  = 1'b1;
					end
				end
			end
			PH_SSC2: begin
				res.sdata_oe = 1'b1;
				res.busy_res = 1'b1;
			end
			PH_TX: begin
				res.sdata_out  = tx_q[TX_W-1];
				res.sdata_oe   = 1'b1;
				res.sclk_pulse = 1'b1;
				res.busy_res   = 1'b1;
			end
			PH_PARK: begin
				res.sdata_oe   = 1'b1;
				res.sclk_pulse = 1'b1;
				res.busy_res   = 1'b1;
				res.done_res   = !is_rd_q;
			end
			PH_RX: begin
				res.sclk_pulse = 1'b1;
				res.busy_res   = 1'b1;
			end
			default: begin
				res.sclk_pulse = 1'b1;
				res.busy_res   = 1'b1;
				res.done_res   = 1'b1;
				res.read_valid = 1'b1;
				res.read_bits  = rx_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			cnt_q    <= '0;
			tx_q     <= '0;
			tx_len_q <= '0;
			rx_len_q <= '0;
			rx_q     <= '0;
			is_rd_q  <= 1'b0;
		end else if (take) begin
			case (phase_q)
				PH_IDLE: begin
					if (ctl.start && !ctl.addr_err) begin
						tx_q     <= frame;
						tx_len_q <= tx_len;
						rx_len_q <= rx_len;
						is_rd_q  <= ctl.is_read;
						rx_q     <= '0;
						phase_q  <= PH_SSC2;
					end
				end
				PH_SSC2: begin
					cnt_q   <= '0;
					phase_q <= PH_TX;
				end
				PH_TX: begin
					tx_q  <= tx_q << 1;
					cnt_q <= cnt_inc[CNT_W-1:0];
					if (cnt_inc >= {1'b0, tx_len_q}) begin
						phase_q <= PH_PARK;
					end
				end
				PH_PARK: begin
					cnt_q   <= '0;
					phase_q <= is_rd_q ? PH_RX : PH_IDLE;
				end
				PH_RX: begin
					rx_q  <= {rx_q[RX_W-2:0], ctl.sdin};
					cnt_q <= cnt_inc[CNT_W-1:0];
					if (cnt_inc >= {1'b0, rx_len_q}) begin
						phase_q <= PH_PARK2;
					end
				end
				default: begin
					cnt_q   <= '0;
					phase_q <= PH_IDLE;
				end
			endcase
		end
	end

	`RBM_ASSERT_NOW(a_tx_in_range, take && phase_q == PH_TX, cnt_q < tx_len_q)
	`RBM_ASSERT_NXT(a_reject_idle, take && res.addr_error, phase_q == PH_IDLE)
	`RBM_ASSERT_NXT(a_done_idle, take && res.done_res, phase_q == PH_IDLE && cnt_q == '0)
	`RBM_ASSERT_NXT(a_hold, !take, $stable(phase_q) && $stable(cnt_q))

endmodule

>>> src/rffe_bus_master_core.sv
// RFFE-style bus master, one transfer per bus bit period.
// Input push/full and result empty/pop behave as FIFOs; a cfg channel sets
// the highest accepted extended register address (reset 0xBE).
// Each pushed item is one bit period and yields exactly one result item.
// A start item while idle sends a sequence start, a command frame with odd
// parity, address and data words, a bus park and, on reads, the read bits
// and a second park. Rejected extended addresses give done and addr_error.
// A result reaches the result port through the input queue, then the
// sequencer, which writes it into the result queue where it can be popped.
// Throughput: one item per cycle while pop keeps up; the sequencer takes
// one queued item per cycle when the result queue has room.
// When pop stalls the 2-entry result queue fills, the sequencer holds and
// the 4-entry input queue absorbs pushes until full rises.
// Reset clears both queues and the sequencer (idle) and sets the limit register to 0xBE.
// Config writes are accepted every cycle (cfg_ready high).
// Depends on rbm_pkg, rbm_fifo, rbm_front and rbm_back.
module rffe_bus_master_core #(
	parameter int MAX_BYTES = rbm_pkg::MAX_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        action,
	input  logic [1:0]  kind,
	input  logic [3:0]  slave_addr,
	input  logic [7:0]  target_reg,
	input  logic [2:0]  byte_count,
	input  logic [31:0] write_data,
	input  logic        sdata_in,
	output logic        empty,
	input  logic        pop,
	output logic        sdata_out,
	output logic        sdata_oe,
	output logic        sclk_pulse,
	output logic        busy_res,
	output logic        done_res,
	output logic        read_valid,
	output logic [35:0] read_bits,
	output logic        addr_error,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data
);
	import rbm_pkg::*;

	localparam int TX_W  = CMD_BITS + WORD_BITS * (MAX_BYTES + 1);
	localparam int CNT_W = $clog2(TX_W + 1);
	localparam int IT_W  = $bits(ctl_t) + TX_W + 2 * CNT_W;

	logic [7:0]       limit_q;
	ctl_t             f_ctl, b_ctl;
	logic [TX_W-1:0]  f_frame, b_frame;
	logic [CNT_W-1:0] f_tx_len, f_rx_len, b_tx_len, b_rx_len;
	logic [IT_W-1:0]  iq_dout;
	logic             iq_empty, oq_full, take, out_space;
	res_t             b_res, o_res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= EXT_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			limit_q <= cfg_data;
		end
	end

	rbm_front #(.MAX_BYTES(MAX_BYTES)) u_front (
		.action    (action),
		.kind      (kind),
		.slave_addr(slave_addr),
		.target_reg(target_reg),
		.byte_count(byte_count),
		.write_data(write_data),
		.sdata_in  (sdata_in),
		.ext_limit (limit_q),
		.ctl       (f_ctl),
		.frame     (f_frame),
		.tx_len    (f_tx_len),
		.rx_len    (f_rx_len)
	);

	rbm_fifo #(.W(IT_W), .DEPTH(IQ_DEPTH)) u_iq (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.din   ({f_ctl, f_frame, f_tx_len, f_rx_len}),
		.pop   (take),
		.dout  (iq_dout),
		.full  (full),
		.empty (iq_empty)
	);

	assign {b_ctl, b_frame, b_tx_len, b_rx_len} = iq_dout;
	assign out_space = !oq_full;

	rbm_back #(.MAX_BYTES(MAX_BYTES)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(!iq_empty),
		.out_space (out_space),
		.ctl       (b_ctl),
		.frame     (b_frame),
		.tx_len    (b_tx_len),
		.rx_len    (b_rx_len),
		.take      (take),
		.res       (b_res)
	);

	rbm_fifo #(.W($bits(res_t)), .DEPTH(OQ_DEPTH)) u_oq (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (take),
		.din   (b_res),
		.pop   (pop),
		.dout  (o_res),
		.full  (oq_full),
		.empty (empty)
	);

	assign sdata_out  = o_res.sdata_out;
	assign sdata_oe   = o_res.sdata_oe;
	assign sclk_pulse = o_res.sclk_pulse;
	assign busy_res   = o_res.busy_res;
	assign done_res   = o_res.done_res;
	assign read_valid = o_res.read_valid;
	assign read_bits  = o_res.read_bits;
	assign addr_error = o_res.addr_error;

endmodule
